>>> src/assert_macros.svh
// assertion macros used by the top level of the report encoder
// no dependencies; each macro is a clocked concurrent assertion disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

>>> src/gre_pkg.sv
// shared types and constants of the gamepad report encoder
// no dependencies; used by gre_encode and the top level
package gre_pkg;

   // report styles
   localparam logic [2:0] MODE_SWITCH = 3'd0;
   localparam logic [2:0] MODE_PS3    = 3'd1;
   localparam logic [2:0] MODE_PS4    = 3'd2;
   localparam logic [2:0] MODE_XINPUT = 3'd3;
   localparam logic [2:0] MODE_MIDI   = 3'd4;

   // midi octave shift
   localparam logic [6:0] SHIFT_STEP  = 7'd12;
   localparam logic [6:0] SHIFT_MAX   = 7'd96;
   localparam logic [6:0] SHIFT_RESET = 7'd60;

   // pitch bend values
   localparam logic [6:0] BEND_UP     = 7'd80;
   localparam logic [6:0] BEND_DOWN   = 7'd48;
   localparam logic [6:0] BEND_CENTER = 7'd64;

   localparam logic [3:0] HAT_RELEASED = 4'd8;
   localparam logic [7:0] TRIGGER_FULL = 8'hFF;

   // one controller snapshot
   typedef struct packed {
      logic [3:0]  dpad_bits;
      logic [12:0] button_bits;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
      logic [31:0] touch_mask;
   } snap_type;

   // one report result
   typedef struct packed {
      logic [3:0]         hat_code;
      logic [15:0]        button_word;
      logic [7:0]         button_extra;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
      logic signed [15:0] out_left_x;
      logic signed [15:0] out_left_y;
      logic signed [15:0] out_right_x;
      logic signed [15:0] out_right_y;
      logic [6:0]         note_shift;
      logic [6:0]         bend_value;
      logic [31:0]        touched_zones;
   } rsp_type;

   // state carried from one report to the next
   typedef struct packed {
      logic [5:0] frame_counter;
      logic [6:0] shift_value;
      logic       prev_right;
      logic       prev_left;
   } state_type;

endpackage

>>> src/gre_encode.sv
// combinational report packing for one snapshot and the state update it causes
// depends on gre_pkg
module gre_encode (
   input  logic [2:0]         report_mode,
   input  gre_pkg::snap_type  snap,
   input  gre_pkg::state_type state_cur,
   output gre_pkg::rsp_type   result,
   output gre_pkg::state_type state_next
);

   logic [3:0]  d;
   logic [12:0] b;
   logic [3:0]  hat;
   logic [7:0]  l2_byte;
   logic [7:0]  r2_byte;
   logic [6:0]  shift_up;
   logic [6:0]  shift_both;
   logic [7:0]  shift_sum;
   logic        rise_right;
   logic        rise_left;

   assign d = snap.dpad_bits;
   assign b = snap.button_bits;

   // hat code, diagonals take priority
   always_comb begin
      if (d[0] && d[3]) begin
         hat = 4'd1;
      end else if (d[1] && d[3]) begin
         hat = 4'd3;
      end else if (d[1] && d[2]) begin
         hat = 4'd5;
      end else if (d[0] && d[2]) begin
         hat = 4'd7;
      end else if (d[0]) begin
         hat = 4'd0;
      end else if (d[3]) begin
         hat = 4'd2;
      end else if (d[1]) begin
         hat = 4'd4;
      end else if (d[2]) begin
         hat = 4'd6;
      end else begin
         hat = gre_pkg::HAT_RELEASED;
      end
   end

   assign l2_byte = b[6] ? gre_pkg::TRIGGER_FULL : 8'd0;
   assign r2_byte = b[7] ? gre_pkg::TRIGGER_FULL : 8'd0;

   // octave shift: step up on right edge first, then step down on left edge
   assign rise_right = d[3] && !state_cur.prev_right;
   assign rise_left  = d[2] && !state_cur.prev_left;
   assign shift_sum  = {1'b0, state_cur.shift_value} + {1'b0, gre_pkg::SHIFT_STEP};

   always_comb begin
      if (!rise_right) begin
         shift_up = state_cur.shift_value;
      end else if (shift_sum >= {1'b0, gre_pkg::SHIFT_MAX}) begin
         shift_up = gre_pkg::SHIFT_MAX;
      end else begin
         shift_up = shift_sum[6:0];
      end
      if (!rise_left) begin
         shift_both = shift_up;
      end else if (shift_up <= gre_pkg::SHIFT_STEP) begin
         shift_both = 7'd0;
      end else begin
         shift_both = shift_up - gre_pkg::SHIFT_STEP;
      end
   end

   // per-mode packing
   always_comb begin
      result               = '0;
      result.hat_code      = hat;
      result.bend_value    = gre_pkg::BEND_CENTER;
      state_next           = state_cur;
      case (report_mode)
         gre_pkg::MODE_SWITCH: begin
            result.button_word = {3'b000, b[12:4], b[0], b[1], b[2], b[3]};
            result.out_left_x  = {8'd0, snap.left_x};
            result.out_left_y  = {8'd0, snap.left_y};
            result.out_right_x = {8'd0, snap.right_x};
            result.out_right_y = {8'd0, snap.right_y};
         end
         gre_pkg::MODE_PS3: begin
            result.button_word = {b[3], b[2], b[1], b[0], b[5], b[4], b[7], b[6],
                                  d[2], d[1], d[3], d[0], b[9], b[11], b[10], b[8]};
            result.button_extra  = {7'd0, b[12]};
            result.left_trigger  = l2_byte;
            result.right_trigger = r2_byte;
            result.out_left_x    = {8'd0, snap.left_x};
            result.out_left_y    = {8'd0, snap.left_y};
            result.out_right_x   = {8'd0, snap.right_x};
            result.out_right_y   = {8'd0, snap.right_y};
         end
         gre_pkg::MODE_PS4: begin
            result.button_word = {b[11], b[10], b[9], 1'b0, b[7:4],
                                  b[0], b[1], b[2], b[3], hat};
            result.button_extra  = {state_cur.frame_counter, b[8], b[12]};
            result.left_trigger  = l2_byte;
            result.right_trigger = r2_byte;
            result.out_left_x    = {8'd0, snap.left_x};
            result.out_left_y    = {8'd0, snap.left_y};
            result.out_right_x   = {8'd0, snap.right_x};
            result.out_right_y   = {8'd0, snap.right_y};
            state_next.frame_counter = state_cur.frame_counter + 6'd1;
         end
         gre_pkg::MODE_XINPUT: begin
            result.button_word = {b[0], b[3], b[1], b[2], 1'b0, b[12], b[5], b[4],
                                  b[11], b[10], b[8], b[9], d[3], d[2], d[1], d[0]};
            result.left_trigger  = l2_byte;
            result.right_trigger = r2_byte;
            // x*257 is the byte doubled; the offsets only flip or invert bits
            result.out_left_x    = {snap.left_x, snap.left_x} ^ 16'h8000;
            result.out_left_y    = ~{snap.left_y, snap.left_y} ^ 16'h8000;
            result.out_right_x   = {snap.right_x, snap.right_x} ^ 16'h8000;
            result.out_right_y   = ~{snap.right_y, snap.right_y} ^ 16'h8000;
         end
         gre_pkg::MODE_MIDI: begin
            result.button_word = {10'd0, b[6] | b[7], b[4] | b[5], b[1], b[2], b[3], b[0]};
            result.note_shift    = shift_both;
            result.touched_zones = snap.touch_mask;
            if (d[0]) begin
               result.bend_value = gre_pkg::BEND_UP;
            end else if (d[1]) begin
               result.bend_value = gre_pkg::BEND_DOWN;
            end else begin
               result.bend_value = gre_pkg::BEND_CENTER;
            end
            state_next.shift_value = shift_both;
            state_next.prev_right  = d[3];
            state_next.prev_left   = d[2];
         end
         default: begin
            // unused styles report only the hat code and the centred bend value
         end
      endcase
   end

endmodule

>>> src/gamepad_report_encoder_core.sv
// top level of the gamepad report encoder: input register, packing, result register
// depends on gre_pkg, gre_encode and assert_macros.svh
//
// Packs one controller snapshot into report fields for the style set by the
// report_mode register (0 switch, 1 ps3, 2 ps4, 3 xinput, 4 midi). Each snapshot
// passes through the input register, then the result register; a new one can
// be taken every cycle unless the report channel stalls. The only loop is the
// update of the ps4 frame counter and midi octave shift, done as an item moves
// into the result register. Write report_mode only while no snapshot is in flight.
`include "assert_macros.svh"

module gamepad_report_encoder_core (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_write_data,
   // snapshot channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_dpad_bits,
   input  logic [12:0]        req_button_bits,
   input  logic [7:0]         req_left_x,
   input  logic [7:0]         req_left_y,
   input  logic [7:0]         req_right_x,
   input  logic [7:0]         req_right_y,
   input  logic [31:0]        req_touch_mask,
   // report channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_hat_code,
   output logic [15:0]        rsp_button_word,
   output logic [7:0]         rsp_button_extra,
   output logic [7:0]         rsp_left_trigger,
   output logic [7:0]         rsp_right_trigger,
   output logic signed [15:0] rsp_out_left_x,
   output logic signed [15:0] rsp_out_left_y,
   output logic signed [15:0] rsp_out_right_x,
   output logic signed [15:0] rsp_out_right_y,
   output logic [6:0]         rsp_note_shift,
   output logic [6:0]         rsp_bend_value,
   output logic [31:0]        rsp_touched_zones
);

   logic [2:0]         mode_ff;
   logic               snap_valid_ff;
   gre_pkg::snap_type  snap_ff;
   gre_pkg::snap_type  snap_in;
   logic               rsp_valid_ff;
   gre_pkg::rsp_type   rsp_ff;
   gre_pkg::rsp_type   rsp_in;
   gre_pkg::state_type state_ff;
   gre_pkg::state_type state_in;
   logic               rsp_free;
   logic               advance;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gre_pkg::MODE_SWITCH;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // pipeline flow control
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = snap_valid_ff && rsp_free;
   assign req_ready = !snap_valid_ff || rsp_free;

   assign snap_in = '{dpad_bits:   req_dpad_bits,
                      button_bits: req_button_bits,
                      left_x:      req_left_x,
                      left_y:      req_left_y,
                      right_x:     req_right_x,
                      right_y:     req_right_y,
                      touch_mask:  req_touch_mask};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (req_ready) begin
         snap_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         snap_ff <= snap_in;
      end
   end

   gre_encode u_encode (
      .report_mode (mode_ff),
      .snap        (snap_ff),
      .state_cur   (state_ff),
      .result      (rsp_in),
      .state_next  (state_in)
   );

   // report state, updated as each snapshot moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{frame_counter: 6'd0,
                       shift_value:   gre_pkg::SHIFT_RESET,
                       prev_right:    1'b0,
                       prev_left:     1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hat_code      = rsp_ff.hat_code;
   assign rsp_button_word   = rsp_ff.button_word;
   assign rsp_button_extra  = rsp_ff.button_extra;
   assign rsp_left_trigger  = rsp_ff.left_trigger;
   assign rsp_right_trigger = rsp_ff.right_trigger;
   assign rsp_out_left_x    = rsp_ff.out_left_x;
   assign rsp_out_left_y    = rsp_ff.out_left_y;
   assign rsp_out_right_x   = rsp_ff.out_right_x;
   assign rsp_out_right_y   = rsp_ff.out_right_y;
   assign rsp_note_shift    = rsp_ff.note_shift;
   assign rsp_bend_value    = rsp_ff.bend_value;
   assign rsp_touched_zones = rsp_ff.touched_zones;

   // checks on the report state and on the stalled result register
   `ASSERT_ALWAYS(shift_in_range_a, clock, reset, state_ff.shift_value <= gre_pkg::SHIFT_MAX)
   `ASSERT_NEXT(counter_steps_a, clock, reset, advance && mode_ff == gre_pkg::MODE_PS4,
      state_ff.frame_counter == $past(state_ff.frame_counter) + 6'd1)
   `ASSERT_NEXT(state_holds_a, clock, reset, !advance, $stable(state_ff))
   `ASSERT_NEXT(stalled_rsp_holds_a, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_ff))

endmodule
